[sv/lfsm_pkg.sv]
// ============================================================================
// lfsm_pkg
// Shared types, constants and helpers for the latest-frame slot mailbox.
// ============================================================================
`default_nettype none

package lfsm_pkg;

    localparam int SLOTS    = 4;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int HANDLE_W = 64;
    localparam int CNT_W    = 32;
    localparam int ENTRY_W  = HANDLE_W + 1;   // frame handle plus key flag

    typedef enum logic [2:0] {
        FN_ENQUEUE  = 3'd0,
        FN_ACQUIRE  = 3'd1,
        FN_RELEASE  = 3'd2,
        FN_SHUTDOWN = 3'd3,
        FN_START    = 3'd4
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DROP,
        ST_STORE,
        ST_ACQUIRE,
        ST_RELEASE,
        ST_START_RD,
        ST_START_HELD,
        ST_STATUS
    } t_state;

    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_HANDBACK = 1'b1;

    typedef struct packed {
        logic                kind;
        logic                accepted;
        logic [HANDLE_W-1:0] handle;
        logic                force_key;
        logic [CNT_W-1:0]    dropped;
        logic [CNT_W-1:0]    processed;
        logic                running;
        logic                last;
    } t_result;

    // circular increment over the slot ring
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(SLOTS - 1)) begin
            res = '0;
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/lfsm_ram.sv]
// ============================================================================
// lfsm_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module lfsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[sv/lfsm_ctrl.sv]
// ============================================================================
// lfsm_ctrl
// Operation sequencer: slot bookkeeping, counters and the frame store access.
// ============================================================================
`default_nettype none

module lfsm_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [2:0]                      i_func,
    input  wire logic [lfsm_pkg::HANDLE_W-1:0]   i_handle,
    input  wire logic                            i_force_key,
    input  wire logic                            i_out_free,
    output logic                                 o_emit,
    output lfsm_pkg::t_result                    o_result
);

    lfsm_pkg::t_state r_state, n_state;

    logic [2:0]                    r_func;
    logic [lfsm_pkg::HANDLE_W-1:0] r_handle;
    logic                          r_key;
    logic                          r_acc;
    logic [lfsm_pkg::IDX_W-1:0]    r_write_idx;
    logic [lfsm_pkg::IDX_W-1:0]    r_read_idx;
    logic [lfsm_pkg::IDX_W-1:0]    r_held_idx;
    logic                          r_have_q;
    logic                          r_have_h;
    logic                          r_running;
    logic [lfsm_pkg::CNT_W-1:0]    r_drop;
    logic [lfsm_pkg::CNT_W-1:0]    r_proc;

    logic                          wr_en;
    logic [lfsm_pkg::IDX_W-1:0]    rd_addr;
    logic [lfsm_pkg::IDX_W-1:0]    free_idx;
    logic [lfsm_pkg::ENTRY_W-1:0]  rd_data;
    logic [lfsm_pkg::HANDLE_W-1:0] rd_frame;
    logic                          rd_key;
    logic                          is_stop;

    assign rd_frame = rd_data[lfsm_pkg::ENTRY_W-1:1];
    assign rd_key   = rd_data[0];
    assign is_stop  = (r_func == lfsm_pkg::FN_SHUTDOWN) || (r_func == lfsm_pkg::FN_START);

    // only the held slot can be busy once the queued one is dropped,
    // so the first free slot is the write position or the one after it
    assign free_idx = (r_have_h && (r_write_idx == r_held_idx))
                    ? lfsm_pkg::next_idx(r_write_idx) : r_write_idx;

    lfsm_ram #(
        .WIDTH (lfsm_pkg::ENTRY_W),
        .DEPTH (lfsm_pkg::SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (free_idx),
        .i_wr_data ({r_handle, r_key}),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfsm_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = lfsm_pkg::ST_DISPATCH;
                end
            end
            lfsm_pkg::ST_DISPATCH: begin
                unique case (r_func)
                    lfsm_pkg::FN_ENQUEUE: begin
                        if (!r_running || (r_handle == '0)) begin
                            n_state = lfsm_pkg::ST_STATUS;
                        end else if (r_have_q) begin
                            n_state = lfsm_pkg::ST_DROP;
                        end else begin
                            n_state = lfsm_pkg::ST_STORE;
                        end
                    end
                    lfsm_pkg::FN_ACQUIRE: begin
                        n_state = (r_have_q && !r_have_h) ? lfsm_pkg::ST_ACQUIRE
                                                          : lfsm_pkg::ST_STATUS;
                    end
                    lfsm_pkg::FN_RELEASE: begin
                        n_state = r_have_h ? lfsm_pkg::ST_RELEASE : lfsm_pkg::ST_STATUS;
                    end
                    lfsm_pkg::FN_SHUTDOWN: begin
                        n_state = r_have_q ? lfsm_pkg::ST_DROP : lfsm_pkg::ST_STATUS;
                    end
                    lfsm_pkg::FN_START: begin
                        n_state = r_have_q ? lfsm_pkg::ST_DROP : lfsm_pkg::ST_START_RD;
                    end
                    default: begin
                        n_state = lfsm_pkg::ST_STATUS;
                    end
                endcase
            end
            lfsm_pkg::ST_DROP: begin
                if (i_out_free) begin
                    if (r_func == lfsm_pkg::FN_ENQUEUE) begin
                        n_state = lfsm_pkg::ST_STORE;
                    end else if (r_func == lfsm_pkg::FN_START) begin
                        n_state = lfsm_pkg::ST_START_RD;
                    end else begin
                        n_state = lfsm_pkg::ST_STATUS;
                    end
                end
            end
            lfsm_pkg::ST_STORE: begin
                n_state = lfsm_pkg::ST_STATUS;
            end
            lfsm_pkg::ST_ACQUIRE: begin
                if (i_out_free) begin
                    n_state = lfsm_pkg::ST_IDLE;
                end
            end
            lfsm_pkg::ST_RELEASE: begin
                if (i_out_free) begin
                    n_state = lfsm_pkg::ST_STATUS;
                end
            end
            lfsm_pkg::ST_START_RD: begin
                n_state = lfsm_pkg::ST_START_HELD;
            end
            lfsm_pkg::ST_START_HELD: begin
                if (!r_have_h || i_out_free) begin
                    n_state = lfsm_pkg::ST_STATUS;
                end
            end
            lfsm_pkg::ST_STATUS: begin
                if (i_out_free) begin
                    n_state = lfsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lfsm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: result item, store access
    always_comb begin
        o_ready            = 1'b0;
        o_emit             = 1'b0;
        wr_en              = 1'b0;
        rd_addr            = r_read_idx;
        o_result.kind      = lfsm_pkg::KIND_HANDBACK;
        o_result.accepted  = 1'b0;
        o_result.handle    = rd_frame;
        o_result.force_key = rd_key;
        o_result.dropped   = r_drop;
        o_result.processed = r_proc;
        o_result.running   = r_running;
        o_result.last      = 1'b0;
        unique case (r_state)
            lfsm_pkg::ST_IDLE: begin
                o_ready = 1'b1;
            end
            lfsm_pkg::ST_DISPATCH: begin
                rd_addr = (r_func == lfsm_pkg::FN_RELEASE) ? r_held_idx : r_read_idx;
            end
            lfsm_pkg::ST_DROP: begin
                o_emit           = i_out_free;
                o_result.dropped = r_drop + lfsm_pkg::CNT_W'(1);
            end
            lfsm_pkg::ST_STORE: begin
                wr_en = 1'b1;
            end
            lfsm_pkg::ST_ACQUIRE: begin
                o_emit            = i_out_free;
                o_result.kind     = lfsm_pkg::KIND_STATUS;
                o_result.accepted = 1'b1;
                o_result.last     = 1'b1;
            end
            lfsm_pkg::ST_RELEASE: begin
                rd_addr = r_held_idx;
                o_emit  = i_out_free;
            end
            lfsm_pkg::ST_START_RD: begin
                rd_addr = r_held_idx;
            end
            lfsm_pkg::ST_START_HELD: begin
                rd_addr = r_held_idx;
                o_emit  = r_have_h && i_out_free;
            end
            lfsm_pkg::ST_STATUS: begin
                o_emit             = i_out_free;
                o_result.kind      = lfsm_pkg::KIND_STATUS;
                o_result.accepted  = r_acc;
                o_result.handle    = '0;
                o_result.force_key = 1'b0;
                o_result.last      = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // transaction payload, no reset needed
    always_ff @(posedge i_clk) begin
        if ((r_state == lfsm_pkg::ST_IDLE) && i_valid) begin
            r_func   <= i_func;
            r_handle <= i_handle;
            r_key    <= i_force_key;
        end
        if (r_state == lfsm_pkg::ST_DISPATCH) begin
            r_acc <= is_stop;
        end else if ((r_state == lfsm_pkg::ST_STORE) || (r_state == lfsm_pkg::ST_RELEASE)) begin
            r_acc <= 1'b1;
        end
    end

    // control state and bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfsm_pkg::ST_IDLE;
            r_write_idx <= '0;
            r_read_idx  <= '0;
            r_held_idx  <= '0;
            r_have_q    <= 1'b0;
            r_have_h    <= 1'b0;
            r_running   <= 1'b0;
            r_drop      <= '0;
            r_proc      <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                lfsm_pkg::ST_DISPATCH: begin
                    if (is_stop) begin
                        r_running <= 1'b0;
                    end
                end
                lfsm_pkg::ST_DROP: begin
                    if (i_out_free) begin
                        r_drop   <= r_drop + lfsm_pkg::CNT_W'(1);
                        r_have_q <= 1'b0;
                    end
                end
                lfsm_pkg::ST_STORE: begin
                    r_read_idx  <= free_idx;
                    r_have_q    <= 1'b1;
                    r_write_idx <= lfsm_pkg::next_idx(free_idx);
                end
                lfsm_pkg::ST_ACQUIRE: begin
                    if (i_out_free) begin
                        r_held_idx <= r_read_idx;
                        r_have_q   <= 1'b0;
                        r_have_h   <= 1'b1;
                        r_read_idx <= lfsm_pkg::next_idx(r_read_idx);
                    end
                end
                lfsm_pkg::ST_RELEASE: begin
                    if (i_out_free) begin
                        r_have_h <= 1'b0;
                        r_proc   <= r_proc + lfsm_pkg::CNT_W'(1);
                    end
                end
                lfsm_pkg::ST_START_HELD: begin
                    if (!r_have_h || i_out_free) begin
                        r_write_idx <= '0;
                        r_read_idx  <= '0;
                        r_held_idx  <= '0;
                        r_have_q    <= 1'b0;
                        r_have_h    <= 1'b0;
                        r_drop      <= '0;
                        r_proc      <= '0;
                        r_running   <= 1'b1;
                    end
                end
                default: begin
                    r_running <= r_running;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/latest_frame_slot_mailbox.sv]
// ============================================================================
// latest_frame_slot_mailbox
// Latest-frame mailbox over a ring of frame slots with drop/process counters.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | i_valid / o_ready  | i_func, i_handle, i_force_key
//  out     | output    | o_valid / i_ready  | o_kind, o_accepted, o_out_handle,
//          |           |                    | o_out_force_key, o_dropped_total,
//          |           |                    | o_processed_total, o_is_running,
//          |           |                    | o_last_of_run
//
//  One transaction at a time. A start that hands back both a queued and a
//  held frame emits both hand-back items before its status item. The slot
//  store has a registered read and is read once per frame handed back or
//  acquired.
//  Reset (i_rst_n low, synchronous): all slots free, mailbox stopped,
//  counters zero. The slot store itself is not cleared; free slots are
//  never read.
//  Stalls: a full output register holds the sequencer in place; the next
//  input transaction is taken while the last status item waits downstream.
//
`default_nettype none

module latest_frame_slot_mailbox (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [2:0]                    i_func,
    input  wire logic [lfsm_pkg::HANDLE_W-1:0] i_handle,
    input  wire logic                          i_force_key,
    // output channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_kind,
    output logic                               o_accepted,
    output logic [lfsm_pkg::HANDLE_W-1:0]      o_out_handle,
    output logic                               o_out_force_key,
    output logic [lfsm_pkg::CNT_W-1:0]         o_dropped_total,
    output logic [lfsm_pkg::CNT_W-1:0]         o_processed_total,
    output logic                               o_is_running,
    output logic                               o_last_of_run
);

    logic              out_free;
    logic              emit;
    lfsm_pkg::t_result result;

    logic              r_out_valid;
    lfsm_pkg::t_result r_out;

    // output register can take a new item when empty or being drained
    assign out_free = !r_out_valid || i_ready;

    lfsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_handle    (i_handle),
        .i_force_key (i_force_key),
        .i_out_free  (out_free),
        .o_emit      (emit),
        .o_result    (result)
    );

    // result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_kind            = r_out.kind;
    assign o_accepted        = r_out.accepted;
    assign o_out_handle      = r_out.handle;
    assign o_out_force_key   = r_out.force_key;
    assign o_dropped_total   = r_out.dropped;
    assign o_processed_total = r_out.processed;
    assign o_is_running      = r_out.running;
    assign o_last_of_run     = r_out.last;

endmodule

`default_nettype wire

[test/mailbox_checker.sv]
// ----------------------------------------------------------------------------
// Mailbox checker
// Watches both channels of the latest-frame slot mailbox, predicts the
// result transactions of every accepted input and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mailbox_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel as seen by the block
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic [2:0]                    i_func,
    input  wire logic [lfsm_pkg::HANDLE_W-1:0] i_handle,
    input  wire logic                          i_force_key,
    // output channel as seen by the block
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic                          i_kind,
    input  wire logic                          i_accepted,
    input  wire logic [lfsm_pkg::HANDLE_W-1:0] i_out_handle,
    input  wire logic                          i_out_force_key,
    input  wire logic [lfsm_pkg::CNT_W-1:0]    i_dropped_total,
    input  wire logic [lfsm_pkg::CNT_W-1:0]    i_processed_total,
    input  wire logic                          i_is_running,
    input  wire logic                          i_last_of_run,
    // to the testbench top
    output int                                 o_fail_count,
    output int                                 o_pending
);

    typedef enum logic [1:0] {
        MB_EMPTY   = 2'd0,
        MB_WAITING = 2'd1,
        MB_TAKEN   = 2'd2
    } t_slot_state;

    // mirror of the mailbox
    t_slot_state                   slot_st  [lfsm_pkg::SLOTS];
    logic [lfsm_pkg::HANDLE_W-1:0] slot_fr  [lfsm_pkg::SLOTS];
    logic                          slot_ky  [lfsm_pkg::SLOTS];
    logic [lfsm_pkg::IDX_W-1:0]    wr_ptr;
    logic [lfsm_pkg::IDX_W-1:0]    rd_ptr;
    logic [lfsm_pkg::IDX_W-1:0]    held_ptr;
    logic                          queued_valid;
    logic                          held_valid;
    logic                          mbox_running;
    logic [lfsm_pkg::CNT_W-1:0]    drops;
    logic [lfsm_pkg::CNT_W-1:0]    processed;

    lfsm_pkg::t_result expected_results [$];
    int                step_items;
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic clear_mirror();
        for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
            slot_st[i] = MB_EMPTY;
            slot_fr[i] = '0;
            slot_ky[i] = 1'b0;
        end
        wr_ptr       = '0;
        rd_ptr       = '0;
        held_ptr     = '0;
        queued_valid = 1'b0;
        held_valid   = 1'b0;
        mbox_running = 1'b0;
        drops        = '0;
        processed    = '0;
    endtask

    // Result items carry the counters and run flag as they stand right now.
    task automatic push_result(input logic kind, input logic acc,
                               input logic [lfsm_pkg::HANDLE_W-1:0] h, input logic key,
                               input logic last);
        lfsm_pkg::t_result r;
        r.kind      = kind;
        r.accepted  = acc;
        r.handle    = h;
        r.force_key = key;
        r.dropped   = drops;
        r.processed = processed;
        r.running   = mbox_running;
        r.last      = last;
        expected_results.push_back(r);
        step_items++;
    endtask

    task automatic free_slot(input int i);
        slot_st[i] = MB_EMPTY;
        slot_fr[i] = '0;
        slot_ky[i] = 1'b0;
    endtask

    // Hand back and count whatever frame is waiting.
    task automatic drop_waiting();
        for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
            if (slot_st[i] == MB_WAITING) begin
                drops++;
                if (slot_fr[i] != '0 && step_items < 4)
                    push_result(lfsm_pkg::KIND_HANDBACK, 1'b0, slot_fr[i], slot_ky[i], 1'b0);
                free_slot(i);
            end
        end
        queued_valid = 1'b0;
    endtask

    task automatic predict_mailbox(input logic [2:0] func,
                                   input logic [lfsm_pkg::HANDLE_W-1:0] h,
                                   input logic key);
        logic                          acc;
        logic [lfsm_pkg::HANDLE_W-1:0] st_h;
        logic                          st_k;
        int                            idx;
        acc        = 1'b0;
        st_h       = '0;
        st_k       = 1'b0;
        step_items = 0;
        case (func)
            lfsm_pkg::FN_ENQUEUE: begin
                if (mbox_running && h != '0) begin
                    drop_waiting();
                    for (int off = 0; off < lfsm_pkg::SLOTS; off++) begin
                        idx = (int'(wr_ptr) + off) % lfsm_pkg::SLOTS;
                        if (slot_st[idx] == MB_EMPTY) begin
                            slot_fr[idx] = h;
                            slot_ky[idx] = key;
                            slot_st[idx] = MB_WAITING;
                            rd_ptr       = lfsm_pkg::IDX_W'(idx);
                            queued_valid = 1'b1;
                            wr_ptr       = lfsm_pkg::IDX_W'((idx + 1) % lfsm_pkg::SLOTS);
                            acc          = 1'b1;
                            break;
                        end
                    end
                end
            end
            lfsm_pkg::FN_ACQUIRE: begin
                if (queued_valid && !held_valid) begin
                    idx          = int'(rd_ptr);
                    slot_st[idx] = MB_TAKEN;
                    held_ptr     = rd_ptr;
                    queued_valid = 1'b0;
                    held_valid   = 1'b1;
                    rd_ptr       = lfsm_pkg::IDX_W'((idx + 1) % lfsm_pkg::SLOTS);
                    acc          = 1'b1;
                    st_h         = slot_fr[idx];
                    st_k         = slot_ky[idx];
                end
            end
            lfsm_pkg::FN_RELEASE: begin
                if (held_valid) begin
                    idx = int'(held_ptr);
                    // handed back before the process count moves
                    if (slot_fr[idx] != '0)
                        push_result(lfsm_pkg::KIND_HANDBACK, 1'b0, slot_fr[idx],
                                    slot_ky[idx], 1'b0);
                    free_slot(idx);
                    held_valid = 1'b0;
                    processed++;
                    acc = 1'b1;
                end
            end
            lfsm_pkg::FN_SHUTDOWN: begin
                mbox_running = 1'b0;
                drop_waiting();
                acc = 1'b1;
            end
            lfsm_pkg::FN_START: begin
                mbox_running = 1'b0;
                drop_waiting();
                for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
                    if (slot_fr[i] != '0 && step_items < 4)
                        push_result(lfsm_pkg::KIND_HANDBACK, 1'b0, slot_fr[i], slot_ky[i],
                                    1'b0);
                    free_slot(i);
                end
                wr_ptr       = '0;
                rd_ptr       = '0;
                held_ptr     = '0;
                queued_valid = 1'b0;
                held_valid   = 1'b0;
                drops        = '0;
                processed    = '0;
                mbox_running = 1'b1;
                acc          = 1'b1;
            end
            default: ;
        endcase
        push_result(lfsm_pkg::KIND_STATUS, acc, st_h, st_k, 1'b1);
    endtask

    task automatic compare_result();
        lfsm_pkg::t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 64'(i_kind), 64'd0);
        end else begin
            want = expected_results.pop_front();
            if (i_kind !== want.kind)
                report_mismatch("kind", 64'(i_kind), 64'(want.kind));
            if (i_accepted !== want.accepted)
                report_mismatch("accepted", 64'(i_accepted), 64'(want.accepted));
            if (i_out_handle !== want.handle)
                report_mismatch("out_handle", i_out_handle, want.handle);
            if (i_out_force_key !== want.force_key)
                report_mismatch("out_force_key", 64'(i_out_force_key), 64'(want.force_key));
            if (i_dropped_total !== want.dropped)
                report_mismatch("dropped_total", 64'(i_dropped_total), 64'(want.dropped));
            if (i_processed_total !== want.processed)
                report_mismatch("processed_total", 64'(i_processed_total),
                                64'(want.processed));
            if (i_is_running !== want.running)
                report_mismatch("is_running", 64'(i_is_running), 64'(want.running));
            if (i_last_of_run !== want.last)
                report_mismatch("last_of_run", 64'(i_last_of_run), 64'(want.last));
        end
    endtask

    // Results are compared before the new input is predicted; a result can
    // never belong to an input accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_mirror();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                compare_result();
            if (i_in_valid && i_in_ready)
                predict_mailbox(i_func, i_handle, i_force_key);
        end
        o_pending <= expected_results.size();
    end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Latest-frame slot mailbox testbench
// Directed operations through every special case of the mailbox, then random
// operation streams with random idling on both channels. A separate checker
// predicts and compares every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_OPS   = 96;
    localparam int IDLE_PERCENT = 13;
    localparam int SETTLE       = 12;     // tail after the last result

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [2:0]                    i_func;
    logic [lfsm_pkg::HANDLE_W-1:0] i_handle;
    logic                          i_force_key;
    logic                          o_valid;
    logic                          i_ready;
    logic                          o_kind;
    logic                          o_accepted;
    logic [lfsm_pkg::HANDLE_W-1:0] o_out_handle;
    logic                          o_out_force_key;
    logic [lfsm_pkg::CNT_W-1:0]    o_dropped_total;
    logic [lfsm_pkg::CNT_W-1:0]    o_processed_total;
    logic                          o_is_running;
    logic                          o_last_of_run;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    logic no_idle;

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    latest_frame_slot_mailbox dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_handle          (i_handle),
        .i_force_key       (i_force_key),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_accepted        (o_accepted),
        .o_out_handle      (o_out_handle),
        .o_out_force_key   (o_out_force_key),
        .o_dropped_total   (o_dropped_total),
        .o_processed_total (o_processed_total),
        .o_is_running      (o_is_running),
        .o_last_of_run     (o_last_of_run)
    );

    mailbox_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_func            (i_func),
        .i_handle          (i_handle),
        .i_force_key       (i_force_key),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_kind            (o_kind),
        .i_accepted        (o_accepted),
        .i_out_handle      (o_out_handle),
        .i_out_force_key   (o_out_force_key),
        .i_dropped_total   (o_dropped_total),
        .i_processed_total (o_processed_total),
        .i_is_running      (o_is_running),
        .i_last_of_run     (o_last_of_run),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Consumer side: ready drops with about 13 percent probability, except in the
    // quiet stretch where the sink never stalls.
    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // One input transaction. An optional gap (valid low) comes first; valid
    // then stays high with a steady payload until the block takes it.
    task automatic send_op(input logic [2:0] func, input logic [lfsm_pkg::HANDLE_W-1:0] h,
                           input logic key);
        if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= func;
        i_handle    <= h;
        i_force_key <= key;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Hold the producer off until every predicted result has been seen.
    // The checker's count is registered, hence the leading clock.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [lfsm_pkg::HANDLE_W-1:0] pick_handle();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;                  // rejected: no frame
        else if (roll < 13)
            return '1;
        else
            return {$urandom, $urandom};
    endfunction

    // Mostly producer/consumer traffic; shutdown and start are rare so the
    // mailbox spends most of its time running with frames moving through.
    function automatic logic [2:0] pick_func();
        int roll;
        roll = $urandom_range(99);
        if (roll < 38)      return lfsm_pkg::FN_ENQUEUE;
        else if (roll < 64) return lfsm_pkg::FN_ACQUIRE;
        else if (roll < 88) return lfsm_pkg::FN_RELEASE;
        else if (roll < 92) return lfsm_pkg::FN_SHUTDOWN;
        else if (roll < 97) return lfsm_pkg::FN_START;
        else                return 3'($urandom_range(int'(lfsm_pkg::FN_START) + 1, 7));
    endfunction

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_func      <= lfsm_pkg::FN_ENQUEUE;
        i_handle    <= '0;
        i_force_key <= 1'b0;
        i_ready     <= 1'b0;
        no_idle     <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // nothing works before the first start
        send_op(lfsm_pkg::FN_ENQUEUE, 64'd5, 1'b1);
        send_op(lfsm_pkg::FN_ACQUIRE, '0, 1'b0);
        send_op(lfsm_pkg::FN_RELEASE, '0, 1'b0);
        // codes past start are rejected
        for (int c = int'(lfsm_pkg::FN_START) + 1; c < 8; c++)
            send_op(3'(c), {$urandom, $urandom}, 1'($urandom));
        send_op(lfsm_pkg::FN_START, '0, 1'b0);
        send_op(lfsm_pkg::FN_ENQUEUE, '0, 1'b1);                  // zero handle rejected
        send_op(lfsm_pkg::FN_ENQUEUE, '1, 1'b1);
        send_op(lfsm_pkg::FN_ENQUEUE, 64'd1, 1'b0);               // replaces the waiting one
        send_op(lfsm_pkg::FN_ACQUIRE, '0, 1'b0);
        send_op(lfsm_pkg::FN_ACQUIRE, '0, 1'b0);                  // already holding
        send_op(lfsm_pkg::FN_ENQUEUE, 64'h8000_0000_0000_0001, 1'b1);
        send_op(lfsm_pkg::FN_RELEASE, '0, 1'b0);
        send_op(lfsm_pkg::FN_ACQUIRE, '0, 1'b0);
        send_op(lfsm_pkg::FN_ENQUEUE, 64'h5555_AAAA_5555_AAAA, 1'b0);
        // restart with both a waiting and a held frame
        send_op(lfsm_pkg::FN_START, '0, 1'b0);
        send_op(lfsm_pkg::FN_ENQUEUE, 64'h0123_4567_89AB_CDEF, 1'b1);
        send_op(lfsm_pkg::FN_ACQUIRE, '0, 1'b0);
        send_op(lfsm_pkg::FN_ENQUEUE, 64'hFEDC_BA98_7654_3210, 1'b0);
        // shutdown drops the waiting frame, the held one stays
        send_op(lfsm_pkg::FN_SHUTDOWN, '0, 1'b0);
        send_op(lfsm_pkg::FN_ENQUEUE, 64'd7, 1'b0);               // stopped
        send_op(lfsm_pkg::FN_RELEASE, '0, 1'b0);
        send_op(lfsm_pkg::FN_SHUTDOWN, '0, 1'b0);
        send_op(lfsm_pkg::FN_START, '0, 1'b0);
        wait_drained();

        // --- random ---
        for (int n = 0; n < RANDOM_OPS; n++) begin
            no_idle <= (n >= 40 && n < 70);
            if (n == 60 || n == 95)
                wait_drained();
            send_op(pick_func(), pick_handle(), 1'($urandom));
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
